/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SRTF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SRTF_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* hdl/srtf_pkg.sv */
package srtf_pkg;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_ZERO_BURST = 3'd2;
    localparam logic [2:0] ST_RAN        = 3'd3;
    localparam logic [2:0] ST_IDLE_TICK  = 3'd4;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } srtf_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } srtf_sts_t;

endpackage

/* hdl/srtf_ctrl.sv */
module srtf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  srtf_pkg::srtf_sts_t sts,
    output srtf_pkg::srtf_cmd_t cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // last read word is compared here
            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/srtf_dpath.sv */
`include "assert_macros.svh"

module srtf_dpath
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srtf_pkg::srtf_cmd_t cmd,
    output srtf_pkg::srtf_sts_t sts,
    input  logic                req_type,
    input  logic [7:0]          job_id,
    input  logic [15:0]         burst_len,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [7:0]          run_id,
    output logic                finished,
    output logic [15:0]         now_time,
    output logic [15:0]         turnaround,
    output logic [15:0]         wait_ticks,
    output logic [15:0]         response,
    output logic [15:0]         idle_total
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TB = TIME_BITS;

    // slot table, one read and one write port
    logic [7:0]    mem_job   [SLOTS];
    logic [TB-1:0] mem_arr   [SLOTS];
    logic [15:0]   mem_burst [SLOTS];
    logic [15:0]   mem_left  [SLOTS];
    logic [TB-1:0] mem_first [SLOTS];

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] started_reg;

    logic          req_reg;
    logic [7:0]    job_in_reg;
    logic [15:0]   burst_in_reg;
    logic [IW-1:0] cnt_reg;

    logic          rd_pend_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [7:0]    rd_job_reg;
    logic [TB-1:0] rd_arr_reg;
    logic [15:0]   rd_burst_reg;
    logic [15:0]   rd_left_reg;
    logic [TB-1:0] rd_first_reg;

    logic          best_found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [7:0]    best_job_reg;
    logic [TB-1:0] best_arr_reg;
    logic [15:0]   best_burst_reg;
    logic [15:0]   best_left_reg;
    logic [TB-1:0] best_first_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;

    logic [TB-1:0] time_reg;
    logic [15:0]   idle_reg;
    logic [15:0]   idle_next;

    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [7:0]    out_run_reg;
    logic          out_finished_reg;
    logic [15:0]   out_now_reg;
    logic [15:0]   out_ta_reg;
    logic [15:0]   out_wt_reg;
    logic [15:0]   out_rsp_reg;
    logic [15:0]   out_idle_reg;

    logic          cand_valid;
    logic          cand_ahead;
    logic          cand_take;
    logic          cand_free;

    logic          is_tick;
    logic          zero_burst;
    logic          arr_ok;
    logic          tick_run;
    logic [15:0]   left_dec;
    logic          fin;
    logic [TB-1:0] first_eff;
    logic [32:0]   t_full;
    logic [32:0]   wt_full;
    logic [32:0]   rsp_full;
    logic [15:0]   ta_val;
    logic [15:0]   wt_val;
    logic [15:0]   rsp_val;
    logic [2:0]    st_val;
    logic [31:0]   now_ext;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_job;
    logic [TB-1:0] wr_arr;
    logic [15:0]   wr_burst;
    logic [15:0]   wr_left;
    logic [TB-1:0] wr_first;

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v > 33'h0_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    assign sts.scan_last = (cnt_reg == IW'(SLOTS - 1));
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // scan compare: strict less keeps the lower slot on equal keys
    assign cand_valid = rd_pend_reg && valid_reg[rd_idx_reg];
    assign cand_ahead = (rd_left_reg < best_left_reg)
                     || ((rd_left_reg == best_left_reg) && (rd_arr_reg < best_arr_reg))
                     || ((rd_left_reg == best_left_reg) && (rd_arr_reg == best_arr_reg)
                         && (rd_job_reg < best_job_reg));
    assign cand_take  = cand_valid && (!best_found_reg || cand_ahead);
    assign cand_free  = rd_pend_reg && !valid_reg[rd_idx_reg] && !free_found_reg;

    assign is_tick    = (req_reg == srtf_pkg::REQ_TICK);
    assign zero_burst = (burst_in_reg == 16'd0);
    assign arr_ok     = !is_tick && !zero_burst && free_found_reg;
    assign tick_run   = is_tick && best_found_reg;

    assign left_dec  = best_left_reg - 16'd1;
    assign fin       = (left_dec == 16'd0);
    assign first_eff = started_reg[best_idx_reg] ? best_first_reg : time_reg;
    assign t_full    = 33'(time_reg) - 33'(best_arr_reg) + 33'd1;
    assign wt_full   = t_full - 33'(best_burst_reg);
    assign rsp_full  = 33'(first_eff) - 33'(best_arr_reg);
    assign ta_val    = sat16(t_full);
    // negative wait only under time saturation
    assign wt_val    = (t_full >= 33'(best_burst_reg)) ? sat16(wt_full) : 16'd0;
    assign rsp_val   = sat16(rsp_full);
    assign now_ext   = 32'(time_reg);

    always_comb
    begin
        priority if (is_tick && best_found_reg)
        begin
            st_val = srtf_pkg::ST_RAN;
        end
        else if (is_tick)
        begin
            st_val = srtf_pkg::ST_IDLE_TICK;
        end
        else if (zero_burst)
        begin
            st_val = srtf_pkg::ST_ZERO_BURST;
        end
        else if (!free_found_reg)
        begin
            st_val = srtf_pkg::ST_FULL;
        end
        else
        begin
            st_val = srtf_pkg::ST_ACCEPTED;
        end
    end

    assign idle_next = (is_tick && !best_found_reg && (idle_reg != 16'hFFFF))
                     ? idle_reg + 16'd1 : idle_reg;

    assign wr_en    = cmd.commit && (arr_ok || tick_run);
    assign wr_idx   = is_tick ? best_idx_reg   : free_idx_reg;
    assign wr_job   = is_tick ? best_job_reg   : job_in_reg;
    assign wr_arr   = is_tick ? best_arr_reg   : time_reg;
    assign wr_burst = is_tick ? best_burst_reg : burst_in_reg;
    assign wr_left  = is_tick ? left_dec       : burst_in_reg;
    assign wr_first = is_tick ? first_eff      : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_job[wr_idx]   <= wr_job;
            mem_arr[wr_idx]   <= wr_arr;
            mem_burst[wr_idx] <= wr_burst;
            mem_left[wr_idx]  <= wr_left;
            mem_first[wr_idx] <= wr_first;
        end
        if (cmd.issue)
        begin
            rd_job_reg   <= mem_job[cnt_reg];
            rd_arr_reg   <= mem_arr[cnt_reg];
            rd_burst_reg <= mem_burst[cnt_reg];
            rd_left_reg  <= mem_left[cnt_reg];
            rd_first_reg <= mem_first[cnt_reg];
        end
    end

    // payload and best-candidate registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req_type;
            job_in_reg   <= job_id;
            burst_in_reg <= burst_len;
        end
        if (cand_take)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_job_reg   <= rd_job_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
            best_left_reg  <= rd_left_reg;
            best_first_reg <= rd_first_reg;
        end
        if (cand_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg   <= st_val;
            out_run_reg      <= (arr_ok ? job_in_reg : (tick_run ? best_job_reg : 8'd0));
            out_finished_reg <= tick_run && fin;
            out_now_reg      <= now_ext[15:0];
            out_ta_reg       <= (tick_run && fin) ? ta_val  : 16'd0;
            out_wt_reg       <= (tick_run && fin) ? wt_val  : 16'd0;
            out_rsp_reg      <= (tick_run && fin) ? rsp_val : 16'd0;
            out_idle_reg     <= idle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            started_reg    <= '0;
            time_reg       <= '0;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue;
            if (cmd.issue)
            begin
                rd_idx_reg <= cnt_reg;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                cnt_reg        <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cand_take)
                begin
                    best_found_reg <= 1'b1;
                end
                if (cand_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                if (arr_ok)
                begin
                    valid_reg[free_idx_reg]   <= 1'b1;
                    started_reg[free_idx_reg] <= 1'b0;
                end
                if (tick_run)
                begin
                    if (fin)
                    begin
                        valid_reg[best_idx_reg]   <= 1'b0;
                        started_reg[best_idx_reg] <= 1'b0;
                    end
                    else
                    begin
                        started_reg[best_idx_reg] <= 1'b1;
                    end
                end
                if (is_tick && (time_reg != {TB{1'b1}}))
                begin
                    time_reg <= time_reg + 1'b1;
                end
                idle_reg <= idle_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign run_id     = out_run_reg;
    assign finished   = out_finished_reg;
    assign now_time   = out_now_reg;
    assign turnaround = out_ta_reg;
    assign wait_ticks = out_wt_reg;
    assign response   = out_rsp_reg;
    assign idle_total = out_idle_reg;

    `SRTF_ASSERT(a_commit_fills_out, clk, rst_n, cmd.commit |=> out_valid_reg, "commit did not load output")
    `SRTF_ASSERT(a_fin_only_on_run, clk, rst_n, (out_valid_reg && out_finished_reg) |-> (out_status_reg == srtf_pkg::ST_RAN), "finished without a run")
    `SRTF_ASSERT(a_time_monotonic, clk, rst_n, 1'b1 |=> (time_reg >= $past(time_reg)), "time went backwards")
    `SRTF_NEVER(a_started_needs_valid, clk, rst_n, |(started_reg & ~valid_reg), "started flag on a free slot")

endmodule

/* hdl/srtf_tick_scheduler.sv */
// Shortest-remaining-time scheduler over a table of SLOTS job slots.
// Input channel (in_valid / in_stall): req_type, job_id, burst_len. An
// arrival stores a job stamped with the current time; a tick runs the job
// with least time left (ties: earlier arrival, lower id, lower slot).
// Output channel (out_valid / out_stall): one result per transaction with
// status, run_id, finished, now_time, the finish metrics and the idle count.
// Every transaction sweeps the whole slot table through its single read
// port, one slot per cycle, and the next transaction is taken only after
// the current one has been written back to the output register.
// in_stall is low only while the block is idle. The result sits in an
// output register: a stalled receiver holds it steady, and the next
// transaction may still be accepted and scanned, waiting at the write-back
// step until that register is free.
// Reset clears slot valid and started flags, time and idle count; slot
// contents are not reset and count only once their slot is valid.
module srtf_tick_scheduler
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  job_id,
    input  logic [15:0] burst_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  run_id,
    output logic        finished,
    output logic [15:0] now_time,
    output logic [15:0] turnaround,
    output logic [15:0] wait_ticks,
    output logic [15:0] response,
    output logic [15:0] idle_total
);

    srtf_pkg::srtf_cmd_t cmd;
    srtf_pkg::srtf_sts_t sts;

    srtf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    srtf_dpath
    #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .job_id     (job_id),
        .burst_len  (burst_len),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .run_id     (run_id),
        .finished   (finished),
        .now_time   (now_time),
        .turnaround (turnaround),
        .wait_ticks (wait_ticks),
        .response   (response),
        .idle_total (idle_total)
    );

endmodule
